>>> hw/rtl/mfd_pkg.sv
// Shared types and constants for the microphone front end (downmix, DC block, gain).
// No dependencies; compile first.
package mfd_pkg;

   localparam int COEFF_FRAC_BITS_DEF = 15;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_TDM_MODE   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_GAIN = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SPIKE_THR  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CLIP_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DC_COEFF   = 3'd4;

   localparam logic        TDM_MODE_RST   = 1'b1;
   localparam logic [6:0]  START_GAIN_RST = 7'd24;
   localparam logic [15:0] SPIKE_THR_RST  = 16'd8000;
   localparam logic [7:0]  CLIP_LIMIT_RST = 8'd8;
   localparam logic [14:0] DC_COEFF_RST   = 15'd32604;

   localparam logic [15:0] SAMPLE_POS_SAT = 16'h7fff;
   localparam logic [15:0] SAMPLE_NEG_SAT = 16'h8000;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_LO,
      ST_MUL_HI,
      ST_SUM,
      ST_RND,
      ST_YNEW,
      ST_FILT,
      ST_SPK,
      ST_GAIN,
      ST_DONE
   } mfd_state_type;

   typedef struct packed {
      logic load;
      logic mul_lo;
      logic mul_hi;
      logic sum;
      logic rnd;
      logic ynew;
      logic filt;
      logic spk;
      logic mul_gain;
      logic finish;
   } mfd_cmd_type;

   typedef struct packed {
      logic out_free;
   } mfd_stat_type;

endpackage

>>> hw/rtl/mfd_if.sv
// Handshake channels of the microphone front end: frame request and sample response.
// Standalone; no package needed.
interface mfd_req_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] slot_a;
   logic signed [31:0] slot_b;
   logic signed [31:0] slot_c;
   logic signed [31:0] slot_d;

   modport source (output valid, output slot_a, output slot_b, output slot_c,
                   output slot_d, input ready);
   modport sink   (input valid, input slot_a, input slot_b, input slot_c,
                   input slot_d, output ready);
endinterface

interface mfd_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] sample_out;
   logic               clipped;
   logic               spike;
   logic [6:0]         gain_now;

   modport source (output valid, output sample_out, output clipped, output spike,
                   output gain_now, input ready);
   modport sink   (input valid, input sample_out, input clipped, input spike,
                   input gain_now, output ready);
endinterface

>>> hw/rtl/mfd_ctrl.sv
// Sequencer for the front end: walks one frame through the datapath steps.
// Depends on mfd_pkg (state, command and status types).
module mfd_ctrl import mfd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  mfd_stat_type stat,
   output mfd_cmd_type  cmd
);

   mfd_state_type state_ff;
   mfd_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MUL_LO;
            end
         end
         ST_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.rnd  = 1'b1;
            state_in = ST_YNEW;
         end
         ST_YNEW: begin
            cmd.ynew = 1'b1;
            state_in = ST_FILT;
         end
         ST_FILT: begin
            cmd.filt = 1'b1;
            state_in = ST_SPK;
         end
         ST_SPK: begin
            cmd.spk  = 1'b1;
            state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.mul_gain = 1'b1;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register is free
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> hw/rtl/mfd_datapath.sv
// Datapath of the front end: registers, shared multiplier, DC blocker, spike and gain logic.
// Depends on mfd_pkg; driven by mfd_ctrl commands.
module mfd_datapath import mfd_pkg::*; #(
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  mfd_cmd_type           cmd,
   output mfd_stat_type          stat,
   input  logic signed [31:0]    slot_a,
   input  logic signed [31:0]    slot_b,
   input  logic signed [31:0]    slot_d,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic signed [15:0]    sample_out,
   output logic                  clipped,
   output logic                  spike,
   output logic [6:0]            gain_now
);

   localparam int F      = COEFF_FRAC_BITS;
   localparam int Y_W    = 40;
   localparam int X_W    = 16;
   localparam int DX_W   = X_W + 1;
   localparam int LO_W   = 20;
   localparam int HP_W   = 35;
   localparam int FULL_W = 56;
   localparam int RND_W  = FULL_W + 1 - F;
   localparam int SUM_W  = ((DX_W + F > RND_W) ? DX_W + F : RND_W) + 1;
   localparam int F24_W  = 24;
   localparam int RY_W   = Y_W + 1 - F;
   localparam int RYX_W  = (RY_W > F24_W) ? RY_W : F24_W + 1;
   localparam int MA_W   = 25;
   localparam int MB_W   = 16;
   localparam int MP_W   = MA_W + MB_W;
   localparam logic [FULL_W:0] HALF_FULL = {{FULL_W{1'b0}}, 1'b1} << (F - 1);
   localparam logic [Y_W:0]    HALF_Y    = {{Y_W{1'b0}}, 1'b1} << (F - 1);

   // configuration
   logic        tdm_ff;
   logic [15:0] thr_ff;
   logic [7:0]  clim_ff;
   logic [14:0] coeff_ff;
   logic [6:0]  gain_ff;
   logic [6:0]  gain_in;
   logic [7:0]  event_ff;
   logic [7:0]  event_in;

   // filter state
   logic signed [X_W-1:0]   last_in_ff;
   logic signed [Y_W-1:0]   last_out_ff;
   logic signed [F24_W-1:0] last_f_ff;

   // per-item working registers
   logic signed [X_W-1:0]    x_ff;
   logic signed [DX_W-1:0]   dx_ff;
   logic signed [MP_W-1:0]   p_lo_ff;
   logic signed [MP_W-1:0]   p_hi_ff;
   logic signed [FULL_W-1:0] full_ff;
   logic signed [RND_W-1:0]  rnd_ff;
   logic signed [F24_W-1:0]  filt_ff;
   logic signed [F24_W-1:0]  sel_ff;
   logic                     spike_ff;

   // response register
   logic               rsp_valid_ff;
   logic signed [15:0] sample_ff;
   logic               clipped_ff;
   logic               spike_out_ff;
   logic [6:0]         gain_now_ff;

   // downmix
   logic signed [X_W-1:0] m1;
   logic signed [X_W-1:0] m2;
   logic [DX_W-1:0]       msum;
   logic [DX_W-1:0]       msum_adj;
   logic signed [X_W-1:0] x_in;

   always_comb begin
      m1       = tdm_ff ? slot_b[31:16] : slot_a[31:16];
      m2       = tdm_ff ? slot_d[31:16] : slot_b[31:16];
      msum     = DX_W'(m1) + DX_W'(m2);
      msum_adj = msum + {{(DX_W-1){1'b0}}, msum[DX_W-1]};
      x_in     = msum_adj[DX_W-1:1];
   end

   // shared multiplier
   logic signed [MA_W-1:0] mul_a;
   logic signed [MB_W-1:0] mul_b;
   logic signed [MP_W-1:0] mul_p;

   always_comb begin
      if (cmd.mul_gain) begin
         mul_a = MA_W'(sel_ff);
         mul_b = {{(MB_W-7){1'b0}}, gain_ff};
      end else if (cmd.mul_hi) begin
         mul_a = MA_W'($signed(last_out_ff[Y_W-1:LO_W]));
         mul_b = {{(MB_W-15){1'b0}}, coeff_ff};
      end else begin
         mul_a = {{(MA_W-LO_W){1'b0}}, last_out_ff[LO_W-1:0]};
         mul_b = {{(MB_W-15){1'b0}}, coeff_ff};
      end
      mul_p = mul_a * mul_b;
   end

   // R * y_prev, rounded
   logic [FULL_W-1:0] full_in;
   logic [FULL_W:0]   tf;

   always_comb begin
      full_in = {{(FULL_W-HP_W-LO_W){p_hi_ff[HP_W-1]}}, p_hi_ff[HP_W-1:0], {LO_W{1'b0}}}
              + {{(FULL_W-HP_W){1'b0}}, p_lo_ff[HP_W-1:0]};
      tf = {full_ff[FULL_W-1], full_ff} + HALF_FULL
         - {{FULL_W{1'b0}}, full_ff[FULL_W-1]};
   end

   // new y, saturated to 40 bits
   logic signed [SUM_W-1:0] dxs;
   logic signed [SUM_W-1:0] ysum;
   logic [SUM_W-Y_W:0]      y_top;
   logic signed [Y_W-1:0]   y_in;

   always_comb begin
      dxs   = SUM_W'(dx_ff) <<< F;
      ysum  = dxs + SUM_W'(rnd_ff);
      y_top = ysum[SUM_W-1:Y_W-1];
      if ((&y_top) || !(|y_top)) begin
         y_in = ysum[Y_W-1:0];
      end else begin
         y_in = ysum[SUM_W-1] ? {1'b1, {(Y_W-1){1'b0}}} : {1'b0, {(Y_W-1){1'b1}}};
      end
   end

   // integer part of y, saturated to 24 bits
   logic [Y_W:0]            ty;
   logic signed [RY_W-1:0]  ry;
   logic signed [RYX_W-1:0] ryx;
   logic [RYX_W-F24_W:0]    r_top;
   logic signed [F24_W-1:0] filt_in;

   always_comb begin
      ty    = {last_out_ff[Y_W-1], last_out_ff} + HALF_Y
            - {{Y_W{1'b0}}, last_out_ff[Y_W-1]};
      ry    = ty[Y_W:F];
      ryx   = RYX_W'(ry);
      r_top = ryx[RYX_W-1:F24_W-1];
      if ((&r_top) || !(|r_top)) begin
         filt_in = ryx[F24_W-1:0];
      end else begin
         filt_in = ryx[RYX_W-1] ? {1'b1, {(F24_W-1){1'b0}}} : {1'b0, {(F24_W-1){1'b1}}};
      end
   end

   // spike suppression
   logic signed [F24_W:0] delta;
   logic [F24_W:0]        absd;
   logic                  spike_in;
   logic [F24_W:0]        fsum;
   logic [F24_W:0]        fsum_adj;
   logic signed [F24_W-1:0] sel_in;

   always_comb begin
      delta    = (F24_W+1)'(filt_ff) - (F24_W+1)'(last_f_ff);
      absd     = delta[F24_W] ? -delta : delta;
      spike_in = absd > {{(F24_W-15){1'b0}}, thr_ff};
      fsum     = (F24_W+1)'(filt_ff) + (F24_W+1)'(last_f_ff);
      fsum_adj = fsum + {{F24_W{1'b0}}, fsum[F24_W]};
      sel_in   = spike_in ? fsum_adj[F24_W:1] : filt_ff;
   end

   // gain saturation, events, gain halving
   logic [MP_W-16:0]   amp_top;
   logic               clip_in;
   logic signed [15:0] sample_in;
   logic [7:0]         ev1;
   logic [7:0]         ev2;
   logic [6:0]         gain_upd;
   logic [7:0]         ev_upd;

   always_comb begin
      amp_top = p_lo_ff[MP_W-1:15];
      clip_in = !((&amp_top) || !(|amp_top));
      if (clip_in) begin
         sample_in = p_lo_ff[MP_W-1] ? SAMPLE_NEG_SAT : SAMPLE_POS_SAT;
      end else begin
         sample_in = p_lo_ff[15:0];
      end
      ev1 = (spike_ff && (event_ff != 8'hff)) ? event_ff + 8'd1 : event_ff;
      ev2 = (clip_in && (ev1 != 8'hff)) ? ev1 + 8'd1 : ev1;
      if (ev2 >= clim_ff) begin
         gain_upd = (gain_ff > 7'd1) ? {1'b0, gain_ff[6:1]} : gain_ff;
         ev_upd   = 8'd0;
      end else begin
         gain_upd = gain_ff;
         ev_upd   = ev2;
      end
      gain_in  = gain_ff;
      event_in = event_ff;
      if (cmd.finish) begin
         gain_in  = gain_upd;
         event_in = ev_upd;
      end
      if (csr_we && (csr_index == CSR_START_GAIN)) begin
         gain_in = csr_wdata[6:0];
      end
   end

   // configuration and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         tdm_ff       <= TDM_MODE_RST;
         thr_ff       <= SPIKE_THR_RST;
         clim_ff      <= CLIP_LIMIT_RST;
         coeff_ff     <= DC_COEFF_RST;
         gain_ff      <= START_GAIN_RST;
         event_ff     <= 8'd0;
         last_in_ff   <= '0;
         last_out_ff  <= '0;
         last_f_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         gain_ff  <= gain_in;
         event_ff <= event_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_TDM_MODE:   tdm_ff   <= csr_wdata[0];
               CSR_START_GAIN: ;
               CSR_SPIKE_THR:  thr_ff   <= csr_wdata[15:0];
               CSR_CLIP_LIMIT: clim_ff  <= csr_wdata[7:0];
               CSR_DC_COEFF:   coeff_ff <= csr_wdata[14:0];
               default: ;
            endcase
         end
         if (cmd.mul_lo) begin
            last_in_ff <= x_ff;
         end
         if (cmd.ynew) begin
            last_out_ff <= y_in;
         end
         if (cmd.spk) begin
            last_f_ff <= sel_in;
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // working and response payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff <= x_in;
      end
      if (cmd.mul_lo) begin
         dx_ff <= DX_W'(x_ff) - DX_W'(last_in_ff);
      end
      if (cmd.mul_lo || cmd.mul_gain) begin
         p_lo_ff <= mul_p;
      end
      if (cmd.mul_hi) begin
         p_hi_ff <= mul_p;
      end
      if (cmd.sum) begin
         full_ff <= full_in;
      end
      if (cmd.rnd) begin
         rnd_ff <= tf[FULL_W:F];
      end
      if (cmd.filt) begin
         filt_ff <= filt_in;
      end
      if (cmd.spk) begin
         sel_ff   <= sel_in;
         spike_ff <= spike_in;
      end
      if (cmd.finish) begin
         sample_ff    <= sample_in;
         clipped_ff   <= clip_in;
         spike_out_ff <= spike_ff;
         gain_now_ff  <= gain_ff;
      end
   end

   assign stat.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid     = rsp_valid_ff;
   assign sample_out    = sample_ff;
   assign clipped       = clipped_ff;
   assign spike         = spike_out_ff;
   assign gain_now      = gain_now_ff;

endmodule

>>> hw/rtl/mic_frontend_dc_block_agc_unit.sv
// Top level of the microphone front end: downmix, DC blocker, spike suppressor, adaptive gain.
// Depends on mfd_pkg, mfd_if, mfd_ctrl and mfd_datapath.
//
//   channel | direction | handshake        | payload
//   req_if  | in        | valid/ready      | slot_a, slot_b, slot_c, slot_d (32b signed)
//   rsp_if  | out       | valid/ready      | sample_out, clipped, spike, gain_now
//   csr_*   | in        | csr_we, no ready | csr_index (3b), csr_wdata (16b)
//
// A frame is taken only in idle; the result and the next ready show in the same cycle, once
// the frame has walked multiply low, multiply high, sum, round, new y, filter, spike, gain and
// done. The pace is set by one shared 25x16 multiplier used three times (two partial products
// of R*y_prev, then the gain) plus rounding and saturation; done waits for a free response.
// Reset is synchronous and loads register defaults and zero filter state.
// A stalled response holds in its register; a new frame is taken while it waits.
module mic_frontend_dc_block_agc_unit import mfd_pkg::*; #(
   parameter int COEFF_FRAC_BITS = COEFF_FRAC_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   mfd_req_if.sink               req_if,
   mfd_rsp_if.source             rsp_if,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   mfd_cmd_type  cmd;
   mfd_stat_type stat;

   mfd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mfd_datapath #(
      .COEFF_FRAC_BITS (COEFF_FRAC_BITS)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .slot_a     (req_if.slot_a),
      .slot_b     (req_if.slot_b),
      .slot_d     (req_if.slot_d),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .sample_out (rsp_if.sample_out),
      .clipped    (rsp_if.clipped),
      .spike      (rsp_if.spike),
      .gain_now   (rsp_if.gain_now)
   );

endmodule

>>> hw/rtl/mfd_chk.sv
// Port-level checks for the microphone front end top level, attached by bind.
// Depends on mic_frontend_dc_block_agc_unit ports only.
module mfd_chk (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic signed [15:0] sample_out,
   input logic              clipped,
   input logic              spike,
   input logic [6:0]        gain_now
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(sample_out) && $stable(clipped)
         && $stable(spike) && $stable(gain_now))
      else $error("stalled response changed");

   a_clip_value: assert property (@(posedge clock)
      rsp_valid && clipped |-> (sample_out == 16'sh7fff) || (sample_out == -16'sh8000))
      else $error("clipped response not at a rail");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second frame taken while one is in work");

   a_min_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response appeared one cycle after transfer");

endmodule

bind mic_frontend_dc_block_agc_unit mfd_chk u_mfd_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .sample_out (rsp_if.sample_out),
   .clipped    (rsp_if.clipped),
   .spike      (rsp_if.spike),
   .gain_now   (rsp_if.gain_now)
);
